[hdl/cgen_pkg.sv]
package cgen_pkg;

	localparam int unsigned DATA_BITS = 32;
	localparam int unsigned ADDR_BITS = 5;

	localparam logic [16:0] ENV_ONE = 17'h10000;

	typedef enum logic [1:0] {
		ENV_ATTACK,
		ENV_RELEASE,
		ENV_FULL
	} env_kind_t;

	typedef struct packed {
		logic      done;
		logic      last;
		env_kind_t env;
	} item_ctl_t;

	typedef struct packed {
		logic [30:0]        start_step;
		logic signed [23:0] sweep;
		logic [15:0]        fade_samples;
		logic [16:0]        fade_gain;
		logic [14:0]        amplitude;
	} cfg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_POS,
		BK_ROM,
		BK_ENV,
		BK_MUL,
		BK_DIV,
		BK_OUT
	} back_state_t;

endpackage

[hdl/cgen_regs.sv]
module cgen_regs #(
	parameter int COUNT_BITS = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [cgen_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [cgen_pkg::DATA_BITS-1:0]       pwdata,
	output logic [cgen_pkg::DATA_BITS-1:0]       prdata,
	output logic                                 pready,
	output cgen_pkg::cfg_t                       cfg,
	output logic [COUNT_BITS-1:0]                sample_count
);

	localparam logic [2:0] REG_START = 3'd0;
	localparam logic [2:0] REG_SWEEP = 3'd1;
	localparam logic [2:0] REG_COUNT = 3'd2;
	localparam logic [2:0] REG_FADE  = 3'd3;
	localparam logic [2:0] REG_GAIN  = 3'd4;
	localparam logic [2:0] REG_AMP   = 3'd5;

	logic [30:0]           start_q;
	logic [23:0]           sweep_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [15:0]           fade_q;
	logic [16:0]           gain_q;
	logic [14:0]           amp_q;
	logic [2:0]            reg_idx;
	logic                  wr_en;

	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			sweep_q <= '0;
			count_q <= '0;
			fade_q  <= 16'd1;
			gain_q  <= cgen_pkg::ENV_ONE;
			amp_q   <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_START: start_q <= pwdata[30:0];
				REG_SWEEP: sweep_q <= pwdata[23:0];
				REG_COUNT: count_q <= pwdata[COUNT_BITS-1:0];
				REG_FADE:  fade_q  <= pwdata[15:0];
				REG_GAIN:  gain_q  <= pwdata[16:0];
				REG_AMP:   amp_q   <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_START: prdata = {1'b0, start_q};
			REG_SWEEP: prdata = {8'h00, sweep_q};
			REG_COUNT: prdata = cgen_pkg::DATA_BITS'(count_q);
			REG_FADE:  prdata = {16'h0000, fade_q};
			REG_GAIN:  prdata = {15'h0000, gain_q};
			REG_AMP:   prdata = {17'h00000, amp_q};
			default:   prdata = '0;
		endcase
	end

	assign cfg.start_step   = start_q;
	assign cfg.sweep        = sweep_q;
	assign cfg.fade_samples = fade_q;
	assign cfg.fade_gain    = gain_q;
	assign cfg.amplitude    = amp_q;
	assign sample_count     = count_q;

endmodule

[hdl/cgen_front.sv]
module cgen_front #(
	parameter int COUNT_BITS = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic                   restart,
	output logic                   full,
	input  cgen_pkg::cfg_t         cfg,
	input  logic [COUNT_BITS-1:0]  sample_count,
	input  logic                   q_full,
	output logic                   q_wr,
	output cgen_pkg::item_ctl_t    q_ctl,
	output logic [COUNT_BITS-1:0]  q_n,
	output logic [31:0]            q_phase
);

	localparam int CMP_BITS = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

	logic [COUNT_BITS-1:0] index_q;
	logic [31:0]           acc_q;
	logic [31:0]           step_q;

	logic                  accept;
	logic [31:0]           init_step;
	logic [31:0]           sweep_ext;
	logic [COUNT_BITS-1:0] idx;
	logic [31:0]           ph;
	logic [31:0]           st;
	logic [COUNT_BITS:0]   idx_inc;
	logic                  done;
	logic [CMP_BITS-1:0]   idx_w;
	logic [CMP_BITS-1:0]   fade_w;
	logic [CMP_BITS-1:0]   cnt_w;
	logic                  in_attack;
	logic                  in_release;

	assign accept    = push && !q_full;
	assign full      = q_full;
	assign q_wr      = accept;
	assign sweep_ext = {{8{cfg.sweep[23]}}, cfg.sweep};
	assign init_step = {1'b0, cfg.start_step} + {{9{cfg.sweep[23]}}, cfg.sweep[23:1]};

	always_comb begin
		idx        = restart ? '0 : index_q;
		ph         = restart ? '0 : acc_q;
		st         = restart ? init_step : step_q;
		idx_inc    = {1'b0, idx} + (COUNT_BITS+1)'(1);
		done       = idx >= sample_count;
		idx_w      = CMP_BITS'(idx);
		fade_w     = CMP_BITS'(cfg.fade_samples);
		cnt_w      = CMP_BITS'(sample_count);
		in_attack  = idx_w < fade_w;
		in_release = (idx_w + fade_w) > cnt_w;

		q_ctl.done = done;
		q_ctl.last = !done && (idx_inc == {1'b0, sample_count});
		if (in_attack) begin
			q_ctl.env = cgen_pkg::ENV_ATTACK;
		end else if (in_release) begin
			q_ctl.env = cgen_pkg::ENV_RELEASE;
		end else begin
			q_ctl.env = cgen_pkg::ENV_FULL;
		end
		q_n     = in_attack ? idx : (sample_count - idx);
		q_phase = ph;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			acc_q   <= '0;
			step_q  <= '0;
		end else if (accept) begin
			if (done) begin
				index_q <= idx;
				acc_q   <= ph;
				step_q  <= st;
			end else begin
				index_q <= idx_inc[COUNT_BITS-1:0];
				acc_q   <= ph + st;
				step_q  <= st + sweep_ext;
			end
		end
	end

endmodule

[hdl/cgen_queue.sv]
module cgen_queue #(
	parameter int WIDTH = 55
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int DEPTH    = 2;
	localparam int PTR_BITS = $clog2(DEPTH);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [PTR_BITS:0]   count_q;

	assign full  = count_q == (PTR_BITS+1)'(DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + (PTR_BITS+1)'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - (PTR_BITS+1)'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> !empty)
		else $error("queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_BITS+1)'(DEPTH))
		else $error("queue holds more words than its depth");
`endif

endmodule

[hdl/cgen_back.sv]
module cgen_back #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int COUNT_BITS       = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	output logic                   q_rd,
	input  cgen_pkg::item_ctl_t    q_ctl,
	input  logic [COUNT_BITS-1:0]  q_n,
	input  logic [31:0]            q_phase,
	input  cgen_pkg::cfg_t         cfg,
	input  logic                   pop,
	output logic                   empty,
	output logic signed [15:0]     sample,
	output logic                   last,
	output logic                   done_res
);

	localparam int ABITS     = $clog2(SINE_TABLE_DEPTH);
	localparam int PBITS     = ABITS + 2;
	localparam int PROD_BITS = 32 + ABITS + 3;
	localparam int EP_BITS   = COUNT_BITS + 17;

	localparam logic [ABITS+2:0] FOUR_D = (ABITS+3)'(4 * SINE_TABLE_DEPTH);
	localparam logic [PBITS-1:0] D1     = PBITS'(SINE_TABLE_DEPTH);
	localparam logic [PBITS-1:0] D2     = PBITS'(2 * SINE_TABLE_DEPTH);
	localparam logic [PBITS-1:0] D3     = PBITS'(3 * SINE_TABLE_DEPTH);
	localparam logic [ABITS-1:0] K_TOP  = ABITS'(SINE_TABLE_DEPTH - 1);

	localparam logic [16:0] DIVISOR  = 17'd32767;
	localparam logic [16:0] DIVISOR2 = 17'd65534;

	localparam longint unsigned PI_Q30   = 64'd3373259426;
	localparam longint unsigned Q30_HALF = 64'd536870912;

	localparam longint unsigned TAYLOR_D1 = 64'd6;
	localparam longint unsigned TAYLOR_D2 = 64'd20;
	localparam longint unsigned TAYLOR_D3 = 64'd42;
	localparam longint unsigned TAYLOR_D4 = 64'd72;
	localparam longint unsigned TAYLOR_D5 = 64'd110;
	localparam longint unsigned TAYLOR_D6 = 64'd156;

	typedef logic [14:0] rom_t [SINE_TABLE_DEPTH];

	// Quarter-wave table, rounded from a fixed-point Taylor series in Q30.
	function automatic rom_t build_rom();
		rom_t            t;
		longint unsigned theta;
		longint unsigned theta2;
		longint unsigned term;
		longint unsigned v;
		longint          sum;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			theta  = (PI_Q30 * (2 * longint'(k) + 1)) >> (ABITS + 2);
			theta2 = (theta * theta) >> 30;
			term   = theta;
			sum    = longint'(theta);
			term   = ((term * theta2) >> 30) / TAYLOR_D1;
			sum    = sum - longint'(term);
			term   = ((term * theta2) >> 30) / TAYLOR_D2;
			sum    = sum + longint'(term);
			term   = ((term * theta2) >> 30) / TAYLOR_D3;
			sum    = sum - longint'(term);
			term   = ((term * theta2) >> 30) / TAYLOR_D4;
			sum    = sum + longint'(term);
			term   = ((term * theta2) >> 30) / TAYLOR_D5;
			sum    = sum - longint'(term);
			term   = ((term * theta2) >> 30) / TAYLOR_D6;
			sum    = sum + longint'(term);
			if (sum < 0) begin
				sum = 0;
			end
			v = (longint'(sum) * 32767 + Q30_HALF) >> 30;
			if (v > 32767) begin
				v = 32767;
			end
			t[k] = 15'(v);
		end
		return t;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	cgen_pkg::back_state_t state_q;
	cgen_pkg::back_state_t state_d;
	logic                  load_out;

	cgen_pkg::item_ctl_t   ctl_q;
	logic [COUNT_BITS-1:0] n_q;
	logic [31:0]           phase_q;
	logic [PBITS-1:0]      pos_q;
	logic [14:0]           rom_q;
	logic                  neg_q;
	logic [EP_BITS-1:0]    envp_q;
	logic [30:0]           m1_q;
	logic [45:0]           m2_q;
	logic [15:0]           mag_q;

	logic                  out_valid_q;
	logic signed [15:0]    sample_q;
	logic                  last_q;
	logic                  done_q;

	logic [PROD_BITS-1:0]  pos_prod;
	logic [1:0]            quad;
	logic [PBITS-1:0]      base;
	logic [PBITS-1:0]      k_raw;
	logic [ABITS-1:0]      k_lin;
	logic [ABITS-1:0]      rom_addr;
	logic [16:0]           env_c;
	logic [29:0]           scaled;
	logic [14:0]           q_hi;
	logic [16:0]           rem;
	logic [15:0]           quot;

	always_comb begin
		pos_prod = PROD_BITS'(phase_q) * PROD_BITS'(FOUR_D);

		if (pos_q >= D3) begin
			quad = 2'd3;
			base = D3;
		end else if (pos_q >= D2) begin
			quad = 2'd2;
			base = D2;
		end else if (pos_q >= D1) begin
			quad = 2'd1;
			base = D1;
		end else begin
			quad = 2'd0;
			base = '0;
		end
		k_raw    = pos_q - base;
		k_lin    = k_raw[ABITS-1:0];
		rom_addr = quad[0] ? (K_TOP - k_lin) : k_lin;

		case (ctl_q.env)
			cgen_pkg::ENV_ATTACK,
			cgen_pkg::ENV_RELEASE: begin
				if (envp_q > EP_BITS'(cgen_pkg::ENV_ONE)) begin
					env_c = cgen_pkg::ENV_ONE;
				end else begin
					env_c = envp_q[16:0];
				end
			end
			default: env_c = cgen_pkg::ENV_ONE;
		endcase

		// Division by 32767 = 2^15 - 1: the remainder stays below three divisors.
		scaled = m2_q[45:16];
		q_hi   = scaled[29:15];
		rem    = {2'b00, scaled[14:0]} + {2'b00, q_hi};
		if (rem >= DIVISOR2) begin
			quot = {1'b0, q_hi} + 16'd2;
		end else if (rem >= DIVISOR) begin
			quot = {1'b0, q_hi} + 16'd1;
		end else begin
			quot = {1'b0, q_hi};
		end
	end

	always_comb begin
		state_d  = state_q;
		q_rd     = 1'b0;
		load_out = 1'b0;
		case (state_q)
			cgen_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_rd    = 1'b1;
					state_d = cgen_pkg::BK_POS;
				end
			end
			cgen_pkg::BK_POS: state_d = cgen_pkg::BK_ROM;
			cgen_pkg::BK_ROM: state_d = cgen_pkg::BK_ENV;
			cgen_pkg::BK_ENV: state_d = cgen_pkg::BK_MUL;
			cgen_pkg::BK_MUL: state_d = cgen_pkg::BK_DIV;
			cgen_pkg::BK_DIV: state_d = cgen_pkg::BK_OUT;
			cgen_pkg::BK_OUT: begin
				if (!out_valid_q || pop) begin
					load_out = 1'b1;
					if (!q_empty) begin
						q_rd    = 1'b1;
						state_d = cgen_pkg::BK_POS;
					end else begin
						state_d = cgen_pkg::BK_IDLE;
					end
				end
			end
			default: state_d = cgen_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cgen_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			ctl_q   <= q_ctl;
			n_q     <= q_n;
			phase_q <= q_phase;
		end
		case (state_q)
			cgen_pkg::BK_POS: pos_q <= pos_prod[32 +: PBITS];
			cgen_pkg::BK_ROM: begin
				rom_q  <= SINE_ROM[rom_addr];
				neg_q  <= quad[1];
				envp_q <= EP_BITS'(n_q) * EP_BITS'(cfg.fade_gain);
			end
			cgen_pkg::BK_ENV: m1_q <= 31'({17'b0, rom_q} * {15'b0, env_c});
			cgen_pkg::BK_MUL: m2_q <= 46'(m1_q) * 46'(cfg.amplitude);
			cgen_pkg::BK_DIV: mag_q <= ctl_q.done ? '0 : quot;
			default: ;
		endcase
		if (load_out) begin
			sample_q <= neg_q ? (16'd0 - mag_q) : mag_q;
			last_q   <= ctl_q.last;
			done_q   <= ctl_q.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign empty    = !out_valid_q;
	assign sample   = sample_q;
	assign last     = last_q;
	assign done_res = done_q;

`ifndef NO_ASSERTIONS
	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == cgen_pkg::BK_OUT))
		else $error("result word loaded outside the output step");

	a_done_is_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_q) |-> (sample_q == '0 && !last_q))
		else $error("past-end word carries a sample or last flag");

	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> (state_q == cgen_pkg::BK_IDLE || state_q == cgen_pkg::BK_OUT))
		else $error("queue read while a word is still in work");
`endif

endmodule

[hdl/chirp_tone_generator.sv]
// A word accepted on push passes through the queue and the back-end steps POS, ROM, ENV, MUL, DIV and OUT.
// The six-step back-end sequencer takes a new word only once the last one is loaded onto the result ports.
// A two-entry queue between front and back lets push proceed while the back end works.
// Reset is asynchronous and active low; it clears all control state and the sound state.
// Registers reset to zero except fade samples (1) and fade gain (65536).
module chirp_tone_generator #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int COUNT_BITS       = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic                                 restart,
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [15:0]                   sample,
	output logic                                 last,
	output logic                                 done_res,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [cgen_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [cgen_pkg::DATA_BITS-1:0]       pwdata,
	output logic [cgen_pkg::DATA_BITS-1:0]       prdata,
	output logic                                 pready
);

	localparam int QW = $bits(cgen_pkg::item_ctl_t) + COUNT_BITS + 32;

	cgen_pkg::cfg_t        cfg;
	logic [COUNT_BITS-1:0] sample_count;

	logic                  q_wr;
	logic                  q_full;
	logic                  q_rd;
	logic                  q_empty;
	cgen_pkg::item_ctl_t   wr_ctl;
	logic [COUNT_BITS-1:0] wr_n;
	logic [31:0]           wr_phase;
	logic [QW-1:0]         q_wdata;
	logic [QW-1:0]         q_rdata;
	cgen_pkg::item_ctl_t   rd_ctl;
	logic [COUNT_BITS-1:0] rd_n;
	logic [31:0]           rd_phase;

	assign q_wdata = {wr_ctl, wr_n, wr_phase};
	assign {rd_ctl, rd_n, rd_phase} = q_rdata;

	cgen_regs #(
		.COUNT_BITS(COUNT_BITS)
	) u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.cfg         (cfg),
		.sample_count(sample_count)
	);

	cgen_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.restart     (restart),
		.full        (full),
		.cfg         (cfg),
		.sample_count(sample_count),
		.q_full      (q_full),
		.q_wr        (q_wr),
		.q_ctl       (wr_ctl),
		.q_n         (wr_n),
		.q_phase     (wr_phase)
	);

	cgen_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_wr),
		.wdata (q_wdata),
		.full  (q_full),
		.rd    (q_rd),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	cgen_back #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.COUNT_BITS      (COUNT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.q_ctl   (rd_ctl),
		.q_n     (rd_n),
		.q_phase (rd_phase),
		.cfg     (cfg),
		.pop     (pop),
		.empty   (empty),
		.sample  (sample),
		.last    (last),
		.done_res(done_res)
	);

endmodule
